FILE: design/kdp_pkg.sv
// Shared types and constants for the keyboard and display port.
package kdp_pkg;

    // Item kinds carried in the mode field
    typedef enum logic [1:0] {
        MODE_BUS_READ  = 2'd0,
        MODE_BUS_WRITE = 2'd1,
        MODE_KEY_SCAN  = 2'd2,
        MODE_DISP_POLL = 2'd3
    } t_mode;

    // Register map of the port
    typedef enum logic [1:0] {
        REG_KEY_DATA  = 2'd0,
        REG_KEY_CTRL  = 2'd1,
        REG_DISP_DATA = 2'd2,
        REG_DISP_CTRL = 2'd3
    } t_reg_idx;

    localparam int unsigned STROBE_BIT = 7;
    localparam logic [7:0]  KEY_STROBE = 8'h80;
    localparam logic [6:0]  CHAR_CR    = 7'h0D;
    localparam logic [6:0]  CHAR_SPACE = 7'h20;
    localparam logic [6:0]  CHAR_LAST  = 7'h5F;
    localparam logic [6:0]  CHAR_UNDER = 7'h5F;
    localparam logic [6:0]  CASE_GAP   = 7'h20;

    // Input word
    typedef struct packed {
        t_mode      mode;
        t_reg_idx   reg_index;
        logic [7:0] write_data;
        logic [7:0] key_code;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       char_valid;
        logic [6:0] char_code;
    } t_out_word;

    // Filtered host key
    typedef struct packed {
        logic       hit;
        logic [6:0] code;
    } t_key_hit;

endpackage

FILE: design/kdp_if.sv
// Valid/ready channel interfaces for the input and result words.
interface kdp_in_if;
    logic              valid;
    logic              ready;
    kdp_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kdp_out_if;
    logic               valid;
    logic               ready;
    kdp_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/kdp_key_filter.sv
// Host key filter: folds case, maps DEL to underscore, rejects unsupported codes.
module kdp_key_filter (
    input  logic              [7:0] i_key_code,
    output kdp_pkg::t_key_hit       o_key
);

    always_comb begin
        o_key = '0;
        if (i_key_code inside {[8'h61:8'h7A]}) begin
            // lower case to upper case
            o_key.hit  = 1'b1;
            o_key.code = i_key_code[6:0] - kdp_pkg::CASE_GAP;
        end else if (i_key_code == 8'h7F) begin
            o_key.hit  = 1'b1;
            o_key.code = kdp_pkg::CHAR_UNDER;
        end else if (i_key_code inside {[8'h41:8'h5A], [8'h20:8'h40], 8'h5E, 8'h0D}) begin
            o_key.hit  = 1'b1;
            o_key.code = i_key_code[6:0];
        end
    end

endmodule

FILE: design/keyboard_display_port_core.sv
// Keyboard and display port: four registers, bus access, key scan and display poll.
//
//   channel  direction  payload                                 handshake
//   i_req    in         mode, reg_index, write_data, key_code   valid/ready
//   o_rsp    out        read_data, char_valid, char_code         valid/ready
//
// One word in per cycle; its result is in the output register the next cycle.
// Rate is one word per cycle, set by the single output register: a new word is
// taken while that register is empty or is being emptied in the same cycle.
// Synchronous active-low reset clears the four port registers and the output
// valid; i_req.ready stays low while reset is held.
module keyboard_display_port_core (
    input logic       i_clk,
    input logic       i_rst_n,
    kdp_in_if.sink    i_req,
    kdp_out_if.source o_rsp
);

    logic [7:0]         r_key_data, n_key_data;
    logic [7:0]         r_key_ctrl, n_key_ctrl;
    logic [7:0]         r_disp_data, n_disp_data;
    logic [7:0]         r_disp_ctrl, n_disp_ctrl;
    logic               r_out_valid;
    kdp_pkg::t_out_word r_out, n_out;
    logic               accept;
    kdp_pkg::t_key_hit  key;
    logic [6:0]         disp_char;

    // Ready whenever the output register is free or draining
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    kdp_key_filter u_key_filter (
        .i_key_code (i_req.data.key_code),
        .o_key      (key)
    );

    assign disp_char = r_disp_data[6:0];

    // Register update and result for the accepted word
    always_comb begin
        n_key_data  = r_key_data;
        n_key_ctrl  = r_key_ctrl;
        n_disp_data = r_disp_data;
        n_disp_ctrl = r_disp_ctrl;
        n_out       = '0;
        if (accept) begin
            case (i_req.data.mode)
                kdp_pkg::MODE_BUS_READ: begin
                    case (i_req.data.reg_index)
                        kdp_pkg::REG_KEY_DATA: begin
                            n_out.read_data = r_key_data;
                            n_key_ctrl      = '0;   // reading the key drops the strobe
                        end
                        kdp_pkg::REG_KEY_CTRL:  n_out.read_data = r_key_ctrl;
                        kdp_pkg::REG_DISP_DATA: n_out.read_data = r_disp_data;
                        default:                n_out.read_data = r_disp_ctrl;
                    endcase
                end
                kdp_pkg::MODE_BUS_WRITE: begin
                    case (i_req.data.reg_index)
                        kdp_pkg::REG_KEY_DATA:  n_key_data  = i_req.data.write_data;
                        kdp_pkg::REG_KEY_CTRL:  n_key_ctrl  = i_req.data.write_data;
                        kdp_pkg::REG_DISP_DATA: n_disp_data = i_req.data.write_data;
                        default:                n_disp_ctrl = i_req.data.write_data;
                    endcase
                end
                kdp_pkg::MODE_KEY_SCAN: begin
                    // latch a key only when none is pending
                    if (key.hit) begin
                        if (!r_key_ctrl[kdp_pkg::STROBE_BIT]) begin
                            n_key_ctrl = kdp_pkg::KEY_STROBE;
                            n_key_data = {1'b1, key.code};
                        end
                    end else if (r_key_ctrl[kdp_pkg::STROBE_BIT]) begin
                        n_key_ctrl = '0;
                    end
                end
                default: begin
                    // display poll: CR or 0x20..0x5F is printable
                    if (disp_char == kdp_pkg::CHAR_CR ||
                        (disp_char >= kdp_pkg::CHAR_SPACE && disp_char <= kdp_pkg::CHAR_LAST)) begin
                        n_out.char_valid = 1'b1;
                        n_out.char_code  = disp_char;
                    end
                    n_disp_data = '0;
                end
            endcase
        end
    end

    // Port registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_data  <= '0;
            r_key_ctrl  <= '0;
            r_disp_data <= '0;
            r_disp_ctrl <= '0;
        end else begin
            r_key_data  <= n_key_data;
            r_key_ctrl  <= n_key_ctrl;
            r_disp_data <= n_disp_data;
            r_disp_ctrl <= n_disp_ctrl;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

FILE: design/kdp_checker.sv
// Port-level checker for the keyboard and display port, bound to the top level.
module kdp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_mode,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_char_valid,
    input logic [6:0] i_char_code
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_data) &&
        $stable(i_char_valid) && $stable(i_char_code))
        else $error("result word changed while stalled");

    // Every accepted word shows its result in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_out_valid)
        else $error("no result one cycle after accept");

    // Only bus reads return register data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_mode != kdp_pkg::MODE_BUS_READ |=> i_read_data == 8'h00)
        else $error("read data on a word that is not a bus read");

    // Only display polls hand over characters
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_mode != kdp_pkg::MODE_DISP_POLL |=>
        !i_char_valid && i_char_code == 7'h00)
        else $error("character on a word that is not a display poll");

    // A handed-over character is printable
    a_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char_valid |->
        i_char_code == kdp_pkg::CHAR_CR ||
        (i_char_code >= kdp_pkg::CHAR_SPACE && i_char_code <= kdp_pkg::CHAR_LAST))
        else $error("non-printable character handed over");

endmodule

bind keyboard_display_port_core kdp_checker u_kdp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_mode    (i_req.data.mode),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_data  (o_rsp.data.read_data),
    .i_char_valid (o_rsp.data.char_valid),
    .i_char_code  (o_rsp.data.char_code)
);

FILE: tb/tb.sv
// Self-checking testbench for the keyboard and display port core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned LONG_HOLD   = 300;

    logic i_clk;
    logic i_rst_n;

    kdp_in_if  req_ch ();
    kdp_out_if rsp_ch ();

    keyboard_display_port_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the four port registers
    logic [7:0] shadow_key_data;
    logic [7:0] shadow_key_ctrl;
    logic [7:0] shadow_disp_data;
    logic [7:0] shadow_disp_ctrl;

    kdp_pkg::t_out_word pending_results[$];
    int unsigned words_sent;
    int unsigned check_errors;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_request;
    int unsigned hold_left = 0;
    int unsigned stall_cycles = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Host key filter: folds case, maps DEL to underscore, rejects the rest
    function automatic kdp_pkg::t_key_hit filter_host_key(input logic [7:0] k);
        kdp_pkg::t_key_hit h;
        h.hit  = 1'b1;
        h.code = k[6:0];
        if (k >= 8'h61 && k <= 8'h7A)
            h.code = k[6:0] - kdp_pkg::CASE_GAP;
        else if (k == 8'h7F)
            h.code = kdp_pkg::CHAR_UNDER;
        else if ((k >= 8'h41 && k <= 8'h5A) || (k >= 8'h20 && k <= 8'h40) ||
                 k == 8'h5E || k == {1'b0, kdp_pkg::CHAR_CR})
            h.code = k[6:0];
        else
            h.hit = 1'b0;
        return h;
    endfunction

    // Works out the result word of one input word and updates the shadow registers
    function automatic kdp_pkg::t_out_word predict_port_result(input kdp_pkg::t_in_word w);
        kdp_pkg::t_out_word r;
        kdp_pkg::t_key_hit  key;
        logic [6:0] c;
        r = '0;
        case (w.mode)
            kdp_pkg::MODE_BUS_READ: begin
                case (w.reg_index)
                    kdp_pkg::REG_KEY_DATA:  r.read_data = shadow_key_data;
                    kdp_pkg::REG_KEY_CTRL:  r.read_data = shadow_key_ctrl;
                    kdp_pkg::REG_DISP_DATA: r.read_data = shadow_disp_data;
                    default:                r.read_data = shadow_disp_ctrl;
                endcase
                if (w.reg_index == kdp_pkg::REG_KEY_DATA)
                    shadow_key_ctrl = '0;
            end
            kdp_pkg::MODE_BUS_WRITE: begin
                case (w.reg_index)
                    kdp_pkg::REG_KEY_DATA:  shadow_key_data  = w.write_data;
                    kdp_pkg::REG_KEY_CTRL:  shadow_key_ctrl  = w.write_data;
                    kdp_pkg::REG_DISP_DATA: shadow_disp_data = w.write_data;
                    default:                shadow_disp_ctrl = w.write_data;
                endcase
            end
            kdp_pkg::MODE_KEY_SCAN: begin
                key = filter_host_key(w.key_code);
                if (key.hit) begin
                    if (!shadow_key_ctrl[kdp_pkg::STROBE_BIT]) begin
                        shadow_key_ctrl = kdp_pkg::KEY_STROBE;
                        shadow_key_data = kdp_pkg::KEY_STROBE | {1'b0, key.code};
                    end
                end else if (shadow_key_ctrl[kdp_pkg::STROBE_BIT]) begin
                    shadow_key_ctrl = '0;
                end
            end
            default: begin
                c = shadow_disp_data[6:0];
                if (c == kdp_pkg::CHAR_CR ||
                    (c >= kdp_pkg::CHAR_SPACE && c <= kdp_pkg::CHAR_LAST)) begin
                    r.char_valid = 1'b1;
                    r.char_code  = c;
                end
                shadow_disp_data = '0;
            end
        endcase
        return r;
    endfunction

    // Offers one word, with an optional idle gap first, and waits for it to be taken
    task automatic send_word(input kdp_pkg::t_mode m, input kdp_pkg::t_reg_idx r,
                             input logic [7:0] wd, input logic [7:0] kc);
        kdp_pkg::t_in_word w;
        int unsigned gap;
        w.mode       = m;
        w.reg_index  = r;
        w.write_data = wd;
        w.key_code   = kc;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.data  = w;
        req_ch.valid = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(predict_port_result(w));
        words_sent++;
    endtask

    // Sender pause: drop valid and wait for every outstanding result
    task automatic wait_until_drained();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_host_key();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 40) return 8'($urandom_range(8'h61, 8'h7A));
        if (p < 60) return 8'($urandom_range(8'h41, 8'h5A));
        if (p < 72) return 8'($urandom_range(8'h20, 8'h40));
        if (p < 74) return 8'h7F;
        if (p < 76) return 8'h5E;
        if (p < 78) return {1'b0, kdp_pkg::CHAR_CR};
        if (p < 90) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_display_byte();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 60)
            return {1'($urandom),
                    7'($urandom_range(kdp_pkg::CHAR_SPACE, kdp_pkg::CHAR_LAST))};
        if (p < 70) return {1'($urandom), kdp_pkg::CHAR_CR};
        return 8'($urandom);
    endfunction

    // Register reads and writes, reset values and the strobe clear on a key data read
    task automatic test_bus_access();
        int i;
        send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_DATA, 8'h00, 8'hFF);
        for (i = 0; i < 4; i++)
            send_word(kdp_pkg::MODE_BUS_WRITE, kdp_pkg::t_reg_idx'(i), 8'hFF, 8'h00);
        send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_DISP_CTRL, 8'h00, 8'h00);
        send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_CTRL, 8'h00, 8'h00);
        send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_DATA, 8'hFF, 8'hFF);
        send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_CTRL, 8'h00, 8'h00);
        send_word(kdp_pkg::MODE_BUS_WRITE, kdp_pkg::REG_DISP_CTRL, 8'h00, 8'hFF);
    endtask

    // Case folding, DEL, caret, a pending key held off, and strobe drop on no key
    task automatic test_key_scan();
        logic [7:0] codes[4];
        int i;
        codes = '{8'h61, 8'h7A, 8'h7F, 8'h5E};
        for (i = 0; i < 4; i++) begin
            send_word(kdp_pkg::MODE_KEY_SCAN, kdp_pkg::REG_DISP_DATA, 8'hFF, codes[i]);
            send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_DATA, 8'h00, 8'h00);
        end
        send_word(kdp_pkg::MODE_KEY_SCAN, kdp_pkg::REG_KEY_DATA, 8'h00, 8'h41);
        send_word(kdp_pkg::MODE_KEY_SCAN, kdp_pkg::REG_KEY_DATA, 8'h00, 8'h20);
        send_word(kdp_pkg::MODE_KEY_SCAN, kdp_pkg::REG_KEY_DATA, 8'h00, 8'h5B);
        send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_DATA, 8'h00, 8'h00);
        send_word(kdp_pkg::MODE_KEY_SCAN, kdp_pkg::REG_DISP_CTRL, 8'hFF, 8'hFF);
    endtask

    // Display polls: bit 7 stripped, printable bounds, clear after every poll
    task automatic test_display_poll();
        logic [7:0] bytes[3];
        int i;
        bytes = '{8'h8D, 8'h5F, 8'h60};
        send_word(kdp_pkg::MODE_DISP_POLL, kdp_pkg::REG_KEY_DATA, 8'h00, 8'h00);
        send_word(kdp_pkg::MODE_DISP_POLL, kdp_pkg::REG_DISP_CTRL, 8'hFF, 8'hFF);
        for (i = 0; i < 3; i++) begin
            send_word(kdp_pkg::MODE_BUS_WRITE, kdp_pkg::REG_DISP_DATA, bytes[i], 8'h00);
            send_word(kdp_pkg::MODE_DISP_POLL, kdp_pkg::REG_DISP_DATA, 8'h00, 8'h00);
        end
    endtask

    // Mostly well-formed key and display sequences, the rest random words
    task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                       input int unsigned n);
        int unsigned target;
        int unsigned pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = words_sent + n;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_word(kdp_pkg::MODE_KEY_SCAN, kdp_pkg::t_reg_idx'($urandom_range(3)),
                          8'($urandom), pick_host_key());
                if ($urandom_range(1) != 0)
                    send_word(kdp_pkg::MODE_KEY_SCAN,
                              kdp_pkg::t_reg_idx'($urandom_range(3)), 8'($urandom),
                              pick_host_key());
                if ($urandom_range(3) != 0)
                    send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_DATA,
                              8'($urandom), 8'($urandom));
                send_word(kdp_pkg::MODE_BUS_READ, kdp_pkg::REG_KEY_CTRL,
                          8'($urandom), 8'($urandom));
            end else if (pick < 65) begin
                if ($urandom_range(4) != 0)
                    send_word(kdp_pkg::MODE_BUS_WRITE, kdp_pkg::REG_DISP_DATA,
                              pick_display_byte(), 8'($urandom));
                send_word(kdp_pkg::MODE_DISP_POLL, kdp_pkg::t_reg_idx'($urandom_range(3)),
                          8'($urandom), 8'($urandom));
            end else begin
                send_word(kdp_pkg::t_mode'($urandom_range(3)),
                          kdp_pkg::t_reg_idx'($urandom_range(3)),
                          8'($urandom), 8'($urandom));
            end
        end
        wait_until_drained();
    endtask

    // Long receiver hold while words keep coming, so the core stalls its input
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = LONG_HOLD;
        for (i = 0; i < 40; i++)
            send_word(kdp_pkg::t_mode'($urandom_range(3)),
                      kdp_pkg::t_reg_idx'($urandom_range(3)),
                      8'($urandom), 8'($urandom));
        wait_until_drained();
    endtask

    // Receiver ready, with random idling and the long hold counted here
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
        end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            check_errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        kdp_pkg::t_out_word want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected: %h", rsp_ch.data);
                check_errors++;
            end else begin
                want = pending_results.pop_front();
                report_field("read_data", 32'(want.read_data),
                             32'(rsp_ch.data.read_data));
                report_field("char_valid", 32'(want.char_valid),
                             32'(rsp_ch.data.char_valid));
                report_field("char_code", 32'(want.char_code),
                             32'(rsp_ch.data.char_code));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sequence of tests
    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.data      = '0;
        shadow_key_data  = '0;
        shadow_key_ctrl  = '0;
        shadow_disp_data = '0;
        shadow_disp_ctrl = '0;
        words_sent       = 0;
        check_errors     = 0;
        send_idle_pct    = 15;
        recv_idle_pct    = 75;
        hold_request     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_bus_access();
        test_key_scan();
        test_display_poll();
        test_random_traffic(15, 75, 560);
        test_random_traffic(75, 15, 560);
        test_backpressure();
        test_random_traffic(0, 0, 560);

        wait_until_drained();
        repeat (8) @(posedge i_clk);
        if (check_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/kdp_pkg.sv
design/kdp_if.sv
design/kdp_key_filter.sv
design/keyboard_display_port_core.sv
design/kdp_checker.sv
tb/tb.sv
